@@ design/homogeneous_point_transform_macros.svh @@
// assertion macros used by the point transform back end
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define HPT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/hpt_pkg.sv @@
// types, constants and helpers of the homogeneous point transform
`timescale 1ns / 1ps
package hpt_pkg;
   localparam int COORD_W    = 32;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 66;
   localparam int MAG_W      = 66;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = 32;
   localparam int DIV_STEPS  = 32;
   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 64;
   localparam int CSR_IDX_W  = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int NUM_LANES  = 3;

   localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_type;

   localparam matrix_type MATRIX_RESET = {
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
      64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};

   typedef struct packed {
      logic                            wz;
      logic                            dneg;
      logic [MAG_W-1:0]                d;
      logic [NUM_LANES-1:0]            nneg;
      logic [NUM_LANES-1:0][MAG_W-1:0] n;
   } job_type;

   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [MAG_W-1:0]     rem;
      logic [FRAC_W-1:0]    nlow;
      logic [Q_W-1:0]       q;
   } lane_type;

   typedef struct packed {
      logic                          valid;
      logic                          wz;
      logic [MAG_W-1:0]              d;
      lane_type [NUM_LANES-1:0]      lane;
   } stage_type;

   typedef struct packed {
      logic                            sat;
      logic                            wz;
      logic [NUM_LANES-1:0][Q_W-1:0]   coord;
   } result_type;

   function automatic logic signed [COORD_W-1:0] coef(matrix_type m, int row, int col);
      logic [REG_W-1:0] r;
      r = m[row * 2 + col / 2];
      return (col % 2 == 1) ? r[REG_W-1:COORD_W] : r[COORD_W-1:0];
   endfunction
endpackage

@@ design/hpt_front.sv @@
// front end: products, row sums and classification of each point
`timescale 1ns / 1ps
module hpt_front import hpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [3*COORD_W-1:0] in_data,
   input  matrix_type           matrix,
   output logic                 push,
   output job_type              job
);
   logic signed [3:0][3:0][PROD_W-1:0] prod_ff, prod_in;
   logic signed [3:0][1:0][SUM_W-1:0]  part_ff, part_in;
   logic signed [3:0][SUM_W-1:0]       sum_ff, sum_in;
   logic [2:0]                         valid_ff, valid_in;
   logic signed [COORD_W-1:0]          px, py, pz;

   assign px = in_data[COORD_W-1:0];
   assign py = in_data[2*COORD_W-1:COORD_W];
   assign pz = in_data[3*COORD_W-1:2*COORD_W];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_in[r][0] = px * coef(matrix, r, 0);
         prod_in[r][1] = py * coef(matrix, r, 1);
         prod_in[r][2] = pz * coef(matrix, r, 2);
         prod_in[r][3] = PROD_W'(coef(matrix, r, 3)) <<< FRAC_W;
         part_in[r][0] = SUM_W'(signed'(prod_ff[r][0])) + SUM_W'(signed'(prod_ff[r][1]));
         part_in[r][1] = SUM_W'(signed'(prod_ff[r][2])) + SUM_W'(signed'(prod_ff[r][3]));
         sum_in[r]     = part_ff[r][0] + part_ff[r][1];
      end
      valid_in = {valid_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
         sum_ff  <= sum_in;
      end
   end

   // magnitudes and signs for the divider
   always_comb begin
      for (int r = 0; r < NUM_LANES; r++) begin
         job.nneg[r] = sum_ff[r][SUM_W-1];
         job.n[r]    = sum_ff[r][SUM_W-1] ? MAG_W'(-sum_ff[r]) : MAG_W'(sum_ff[r]);
      end
      job.dneg = sum_ff[3][SUM_W-1];
      job.d    = sum_ff[3][SUM_W-1] ? MAG_W'(-sum_ff[3]) : MAG_W'(sum_ff[3]);
      job.wz   = (sum_ff[3] == '0);
   end

   assign push = en && valid_ff[2];
endmodule

@@ design/hpt_fifo.sv @@
// small queue between front end and divider
`timescale 1ns / 1ps
module hpt_fifo import hpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);
   job_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

@@ design/hpt_back.sv @@
// back end: pipelined restoring divide, saturation and result register
`timescale 1ns / 1ps
`include "homogeneous_point_transform_macros.svh"
module hpt_back import hpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type result
);
   stage_type  st_ff [DIV_STEPS+1];
   stage_type  st_in [DIV_STEPS+1];
   result_type res_ff, res_in;
   logic       valid_ff, back_en;

   function automatic lane_type step(lane_type l, logic [MAG_W-1:0] d, int i);
      logic [MAG_W:0] t;
      lane_type       o;
      o = l;
      t = {l.rem, (i >= FRAC_W) ? l.nlow[i-FRAC_W] : 1'b0};
      if (t >= {1'b0, d}) begin
         t   = t - {1'b0, d};
         o.q = {l.q[Q_W-2:0], 1'b1};
      end else begin
         o.q = {l.q[Q_W-2:0], 1'b0};
      end
      o.rem = t[MAG_W-1:0];
      return o;
   endfunction

   assign back_en   = !valid_ff || out_ready;
   assign pop       = back_en && job_valid;
   assign out_valid = valid_ff;
   assign result    = res_ff;

   always_comb begin
      st_in[0].valid = job_valid;
      st_in[0].wz    = job.wz;
      st_in[0].d     = job.d;
      for (int r = 0; r < NUM_LANES; r++) begin
         st_in[0].lane[r].neg  = job.nneg[r] ^ job.dneg;
         st_in[0].lane[r].ovf  = {{FRAC_W{1'b0}}, job.n[r]} >= {job.d, {FRAC_W{1'b0}}};
         st_in[0].lane[r].rem  = job.n[r] >> FRAC_W;
         st_in[0].lane[r].nlow = job.n[r][FRAC_W-1:0];
         st_in[0].lane[r].q    = '0;
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         st_in[k] = st_ff[k-1];
         for (int r = 0; r < NUM_LANES; r++) begin
            st_in[k].lane[r] = step(st_ff[k-1].lane[r], st_ff[k-1].d, DIV_STEPS - k);
         end
      end
   end

   // sign, clamp and zero-w handling
   always_comb begin
      res_in.sat = 1'b0;
      res_in.wz  = st_ff[DIV_STEPS].wz;
      for (int r = 0; r < NUM_LANES; r++) begin
         lane_type l;
         l = st_ff[DIV_STEPS].lane[r];
         if (st_ff[DIV_STEPS].wz) begin
            res_in.coord[r] = '0;
         end else if (l.neg) begin
            if (l.ovf || l.q > NEG_LIMIT) begin
               res_in.coord[r] = NEG_LIMIT;
               res_in.sat      = 1'b1;
            end else begin
               res_in.coord[r] = -l.q;
            end
         end else begin
            if (l.ovf || l.q > POS_LIMIT) begin
               res_in.coord[r] = POS_LIMIT;
               res_in.sat      = 1'b1;
            end else begin
               res_in.coord[r] = l.q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k].valid <= 1'b0;
         end
      end else if (back_en) begin
         valid_ff <= st_ff[DIV_STEPS].valid;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k].valid <= st_in[k].valid;
         end
      end
      if (back_en) begin
         res_ff <= res_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k].wz   <= st_in[k].wz;
            st_ff[k].d    <= st_in[k].d;
            st_ff[k].lane <= st_in[k].lane;
         end
      end
   end

   `HPT_ASSERT_SAME(a_zero_w_out, valid_ff && res_ff.wz, res_ff.coord == '0 && !res_ff.sat, "zero w result not cleared")
   `HPT_ASSERT_SAME(a_sat_not_wz, valid_ff && res_ff.sat, !res_ff.wz, "saturation flagged on zero w")
   `HPT_ASSERT_NEXT(a_stall_holds, valid_ff && !out_ready, valid_ff && $stable(res_ff), "result lost while stalled")
endmodule

@@ design/homogeneous_point_transform.sv @@
// top level of the homogeneous 4x4 point transform with perspective divide
//
//  channel  dir  payload
//  req_     in   tdata: point_x, point_y, point_z
//  rsp_     out  tdata: out_x, out_y, out_z; tuser: w_is_zero, saturated
//  csr_     in   index 0..7, 64-bit matrix register, higher index ignored
//
// one point per cycle sustained while rsp_tready stays high; the 32-step
// restoring divider pipeline (one quotient bit per stage, three lanes)
// sits between three front stages plus the queue and the result register
// reset clears the matrix to identity and empties all pipes
// a stalled result stalls the divider; the queue then fills and stops req_
`timescale 1ns / 1ps
module homogeneous_point_transform import hpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [3*COORD_W-1:0] req_tdata,   // point_x, point_y, point_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [3*Q_W-1:0]     rsp_tdata,   // out_x, out_y, out_z
   output logic [7:0]           rsp_tuser,   // w_is_zero, saturated, zero fill
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);
   matrix_type matrix_ff;
   job_type    push_job, pop_job;
   result_type result;
   logic       push, pop, full, empty, front_en;

   assign csr_ready  = 1'b1;
   assign front_en   = !full;
   assign req_tready = front_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_RESET;
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         matrix_ff[csr_index[$clog2(NUM_REGS)-1:0]] <= csr_wdata;
      end
   end

   hpt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (front_en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .matrix   (matrix_ff),
      .push     (push),
      .job      (push_job)
   );

   hpt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .full      (full),
      .empty     (empty)
   );

   hpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!empty),
      .job       (pop_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {result.coord[2], result.coord[1], result.coord[0]};
   assign rsp_tuser = {6'b0, result.sat, result.wz};
endmodule

@@ test/tb_top.sv @@
// self-checking testbench of the homogeneous 4x4 point transform
`timescale 1ns / 1ps
module tb_top;
   import hpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;
   localparam logic [7:0] FLAG_W_ZERO = 8'h01;
   localparam logic [7:0] FLAG_SAT    = 8'h02;
   localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

   class transform_predictor;
      logic [REG_W-1:0] coefs [NUM_REGS];
      logic [3*Q_W-1:0] expected_coords [$];
      logic [7:0]       expected_flags [$];

      function new();
         foreach (coefs[i]) coefs[i] = MATRIX_RESET[i];
      endfunction

      function void write_reg(int idx, logic [REG_W-1:0] value);
         if (idx < NUM_REGS) coefs[idx] = value;
      endfunction

      function longint coef_at(int row, int col);
         logic [REG_W-1:0] r;
         r = coefs[row * 2 + col / 2];
         return longint'(signed'(col % 2 ? r[63:32] : r[31:0]));
      endfunction

      function logic [Q_W-1:0] quotient(logic signed [127:0] num, logic signed [127:0] den,
                                        inout logic sat);
         logic [127:0] n, d, q;
         logic neg;
         n = num < 0 ? -num : num;
         d = den < 0 ? -den : den;
         neg = (num < 0) != (den < 0);
         q = (n << FRAC_W) / d;
         if (neg) begin
            if (q > 128'h8000_0000) begin
               sat = 1'b1;
               q = 128'h8000_0000;
            end
            return Q_W'(-q);
         end
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            q = 128'h7FFF_FFFF;
         end
         return q[Q_W-1:0];
      endfunction

      function void note_point(logic [3*COORD_W-1:0] pt);
         longint p [3];
         logic signed [127:0] acc [4];
         logic sat;
         logic [3*Q_W-1:0] res;
         for (int c = 0; c < 3; c++) p[c] = longint'(signed'(pt[c*COORD_W +: COORD_W]));
         for (int r = 0; r < 4; r++) begin
            acc[r] = longint'(ONE_Q16) * coef_at(r, 3);
            for (int c = 0; c < 3; c++) acc[r] += p[c] * coef_at(r, c);
         end
         if (acc[3] == 0) begin
            expected_coords.push_back('0);
            expected_flags.push_back(FLAG_W_ZERO);
         end else begin
            sat = 1'b0;
            for (int r = 0; r < 3; r++) res[r*Q_W +: Q_W] = quotient(acc[r], acc[3], sat);
            expected_coords.push_back(res);
            expected_flags.push_back(sat ? FLAG_SAT : 8'h00);
         end
      endfunction

      function string check_result(logic [3*Q_W-1:0] coords, logic [7:0] flags);
         logic [3*Q_W-1:0] ec;
         logic [7:0] ef;
         if (expected_coords.size() == 0)
            return $sformatf("unexpected response %h/%h", coords, flags);
         ec = expected_coords.pop_front();
         ef = expected_flags.pop_front();
         for (int r = 0; r < 3; r++)
            if (coords[r*Q_W +: Q_W] !== ec[r*Q_W +: Q_W])
               return $sformatf("coord %0d got %h want %h", r, coords[r*Q_W +: Q_W],
                                ec[r*Q_W +: Q_W]);
         if (flags !== ef) return $sformatf("flags got %h want %h", flags, ef);
         return "";
      endfunction

      function int pending();
         return expected_coords.size();
      endfunction
   endclass

   logic                 clock, reset;
   logic                 req_tvalid, req_tready;
   logic [3*COORD_W-1:0] req_tdata;
   logic                 rsp_tvalid, rsp_tready;
   logic [3*Q_W-1:0]     rsp_tdata;
   logic [7:0]           rsp_tuser;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   transform_predictor pred;
   int    errors = 0;
   int    idle_cycles = 0;
   int    rsp_stall = 0;
   bit    no_idle = 0;
   string msg;

   homogeneous_point_transform u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(string text);
      $display("mismatch: %s", text);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         3: return 32'h0;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'h0;
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   task automatic send_point(logic [3*COORD_W-1:0] pt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      do @(posedge clock); while (!req_tready);
      pred.note_point(pt);
   endtask

   task automatic write_csr(int idx, logic [REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      pred.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pred.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_matrix(int kind);
      logic [31:0] lo, hi;
      for (int i = 0; i < NUM_REGS; i++) begin
         lo = rand_coef();
         hi = rand_coef();
         if (kind == 1 && i == 6) {hi, lo} = '0;
         if (kind == 1 && i == 7) begin
            lo = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_0000;
            hi = $urandom_range(0, 1) ? ONE_Q16 : 32'h0;
         end
         if (kind == 2 && i >= 6) {hi, lo} = (i == 7) ? {ONE_Q16, 32'h0} : 64'h0;
         write_csr(i, {hi, lo});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            msg = pred.check_result(rsp_tdata, rsp_tuser);
            if (msg != "") report(msg);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rsp_stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [31:0] edge_vals [5] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, ONE_Q16};
      pred = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix, coordinate extremes
      foreach (edge_vals[i]) send_point({edge_vals[(i + 2) % 5], edge_vals[(i + 1) % 5],
                                         edge_vals[i]});
      wait_idle();

      // tiny w forces clamping both ways, negative w flips signs
      write_csr(7, 64'h0);
      write_csr(6, 64'h0000_0000_0000_0001);
      send_point({32'h0, 32'hFFF0_0000, 32'h0010_0000});
      send_point({32'h0, 32'h0, 32'h8000_0000});
      send_point({32'h0, 32'h7FFF_FFFF, 32'h0});
      send_point({32'h0, 32'h0, 32'h0});
      wait_idle();

      // all-ones and extreme coefficients, ignored high indices
      for (int i = 0; i < NUM_REGS; i++) write_csr(i, i % 2 ? 64'h8000_0000_7FFF_FFFF
                                                             : 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(8, 64'h0);
      write_csr(15, 64'h0);
      send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_point({32'h0, 32'h0, 32'h0});
      send_point({32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000});
      wait_idle();

      // w row zero
      write_csr(6, 64'h0);
      write_csr(7, 64'h0);
      send_point({32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF});
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         no_idle = (phase % 3 == 2);
         load_matrix(phase % 3);
         for (int k = 0; k < 150; k++)
            send_point({rand_coord(), rand_coord(), rand_coord()});
         wait_idle();
      end

      for (int i = 0; i < NUM_REGS; i++) write_csr(i, MATRIX_RESET[i]);
      for (int k = 0; k < 20; k++) send_point({$urandom(), $urandom(), $urandom()});
      wait_idle();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

@@ homogeneous_point_transform.f @@
+incdir+design
design/hpt_pkg.sv
design/hpt_front.sv
design/hpt_fifo.sv
design/hpt_back.sv
design/homogeneous_point_transform.sv
test/tb_top.sv
